// ===== sv/linear_prime_sieve_defines.svh =====
// ----------------------------------------------------------------------------
// linear_prime_sieve_defines: assertion macros
// Shared property shapes for the sieve checkers.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PRIME_SIEVE_DEFINES_SVH
`define LINEAR_PRIME_SIEVE_DEFINES_SVH

// same-cycle implication
`define LPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lps: same-cycle check failed");

// next-cycle implication
`define LPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lps: next-cycle check failed");

`endif

// ===== sv/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Field widths and fixed constants of the linear prime sieve.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int LIMIT_W     = 18;
	localparam int NUMBER_W    = 17;
	localparam int PCOUNT_W    = 15;
	localparam int LIMIT_RESET = 131072;
	localparam int START_VALUE = 2;

endpackage

// ===== sv/lps_ram.sv =====
// ----------------------------------------------------------------------------
// lps_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/linear_prime_sieve.sv =====
// ----------------------------------------------------------------------------
// linear_prime_sieve
// Linear (Euler) sieve, one integer per item, from 2 up to below the limit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  in        in   in_valid / in_stall    restart
//  out       out  out_valid / out_stall  number, is_prime, prime_count, done_res
//  cfg       in   cfg_wr_en              cfg_wr_data (limit_n)
//
//  Normal item: map read, then for each list entry visited a list read,
//  multiply, compare and, if the product is below the limit, map write; an
//  unmarked number adds a bit-serial remainder pass per entry p with
//  p*p <= number. Restart and done items go from accept straight to the
//  output state. Reset and restart run a clearing pass over the map, items
//  held. Output stall holds the result register; one new item is still taken.
// ----------------------------------------------------------------------------
module linear_prime_sieve #(
	parameter int MAX_N       = 131072,
	parameter int PRIME_SLOTS = 16384
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lps_pkg::NUMBER_W-1:0] number,
	output logic                         is_prime,
	output logic [lps_pkg::PCOUNT_W-1:0] prime_count,
	output logic                         done_res,
	input  logic                         cfg_wr_en,
	input  logic [lps_pkg::LIMIT_W-1:0]  cfg_wr_data
);

	localparam int NB  = $clog2(MAX_N);
	localparam int CW  = $clog2(MAX_N + 1);
	localparam int SW  = $clog2(PRIME_SLOTS);
	localparam int KW  = $clog2(PRIME_SLOTS + 1);
	localparam int EW  = (CW > lps_pkg::LIMIT_W) ? CW : lps_pkg::LIMIT_W;
	localparam int PW  = 2 * NB;
	localparam int XW  = (PW > EW) ? PW : EW;
	localparam int DCW = $clog2(NB);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_RD    = 8'b0000_1000,
		S_MUL   = 8'b0001_0000,
		S_CMP   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                        state_q;
	logic [lps_pkg::LIMIT_W-1:0]   limit_q;
	logic [CW-1:0]                 current_q;
	logic [KW-1:0]                 count_q;
	logic [NB-1:0]                 clr_q;
	logic                          after_clear_q;
	logic [NB-1:0]                 n_q;
	logic [NB-1:0]                 spf_q;
	logic [NB-1:0]                 p_q;
	logic [KW-1:0]                 j_q;
	logic [PW-1:0]                 prod_s1;
	logic [PW-1:0]                 sq_s1;
	logic [NB-1:0]                 rem_q;
	logic [DCW-1:0]                div_cnt_q;

	logic [lps_pkg::NUMBER_W-1:0]  res_num_q;
	logic                          res_prime_q;
	logic [lps_pkg::PCOUNT_W-1:0]  res_cnt_q;
	logic                          res_done_q;

	logic                          out_valid_q;
	logic [lps_pkg::NUMBER_W-1:0]  number_q;
	logic                          is_prime_q;
	logic [lps_pkg::PCOUNT_W-1:0]  prime_count_q;
	logic                          done_res_q;

	// memory ports
	logic                          map_we;
	logic [NB-1:0]                 map_waddr;
	logic [NB-1:0]                 map_wdata;
	logic [NB-1:0]                 map_rdata;
	logic                          list_we;
	logic [NB-1:0]                 list_rdata;

	logic                          accept;
	logic [EW-1:0]                 lim;
	logic [EW-1:0]                 lim_cfg;
	logic                          cur_done;
	logic                          app;
	logic [KW-1:0]                 count_nx;
	logic                          prod_ok;
	logic [KW-1:0]                 j_nx;
	logic                          last_j;
	logic                          need_div;
	logic                          div_now;
	logic [NB:0]                   rem_sh;
	logic [NB-1:0]                 rem_nx;
	logic                          div_last;
	logic                          fin_cmp;
	logic                          fin_div;
	logic                          fin;
	logic                          out_free;
	logic                          load;
	state_t                        fin_state;

	// map entry holds the smallest prime factor that marked it, zero if unmarked
	lps_ram #(
		.WIDTH (NB),
		.DEPTH (MAX_N)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (current_q[NB-1:0]),
		.rdata (map_rdata)
	);

	lps_ram #(
		.WIDTH (NB),
		.DEPTH (PRIME_SLOTS)
	) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (count_q[SW-1:0]),
		.wdata (n_q),
		.raddr (j_q[SW-1:0]),
		.rdata (list_rdata)
	);

	assign lim_cfg  = EW'(limit_q);
	assign lim      = (lim_cfg < EW'(MAX_N)) ? lim_cfg : EW'(MAX_N);
	assign cur_done = EW'(current_q) >= lim;
	assign accept   = in_valid && (state_q == S_IDLE);

	assign app      = (map_rdata == '0) && (count_q < KW'(PRIME_SLOTS));
	assign count_nx = count_q + KW'(app);

	assign prod_ok  = XW'(prod_s1) < XW'(lim);
	assign j_nx     = j_q + 1'b1;
	assign last_j   = j_nx == count_q;
	// an unmarked number can only have a factor p with p*p <= number, or itself
	assign need_div = (spf_q == '0) && (sq_s1 <= PW'(n_q));
	assign div_now  = (spf_q != '0) ? (p_q == spf_q) : (p_q == n_q);

	assign rem_sh   = {rem_q, n_q[div_cnt_q]};
	assign rem_nx   = (rem_sh >= {1'b0, p_q}) ? NB'(rem_sh - {1'b0, p_q}) : NB'(rem_sh);
	assign div_last = div_cnt_q == '0;

	assign fin_cmp  = (state_q == S_CMP) && (!prod_ok || (!need_div && (div_now || last_j)));
	assign fin_div  = (state_q == S_DIV) && div_last && ((rem_nx == '0) || last_j);
	assign fin      = fin_cmp || fin_div || (state_q == S_OUT);
	assign out_free = !out_valid_q || !out_stall;
	assign load     = fin && out_free;

	always_comb begin
		if (!load) begin
			fin_state = S_OUT;
		end else if (after_clear_q) begin
			fin_state = S_CLEAR;
		end else begin
			fin_state = S_IDLE;
		end
	end

	always_comb begin
		map_we    = 1'b0;
		map_waddr = clr_q;
		map_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
			end
			S_CMP: begin
				map_we    = prod_ok;
				map_waddr = prod_s1[NB-1:0];
				map_wdata = p_q;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	assign list_we = (state_q == S_CHECK) && app;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			limit_q       <= lps_pkg::LIMIT_W'(lps_pkg::LIMIT_RESET);
			current_q     <= CW'(lps_pkg::START_VALUE);
			count_q       <= '0;
			clr_q         <= '0;
			after_clear_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (load) begin
				out_valid_q   <= 1'b1;
				number_q      <= res_num_q;
				is_prime_q    <= res_prime_q;
				prime_count_q <= res_cnt_q;
				done_res_q    <= res_done_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NB'(MAX_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (restart) begin
							res_num_q     <= '0;
							res_prime_q   <= 1'b0;
							res_cnt_q     <= '0;
							res_done_q    <= 1'b0;
							current_q     <= CW'(lps_pkg::START_VALUE);
							count_q       <= '0;
							clr_q         <= '0;
							after_clear_q <= 1'b1;
							state_q       <= S_OUT;
						end else if (cur_done) begin
							res_num_q     <= '0;
							res_prime_q   <= 1'b0;
							res_cnt_q     <= lps_pkg::PCOUNT_W'(count_q);
							res_done_q    <= 1'b1;
							after_clear_q <= 1'b0;
							state_q       <= S_OUT;
						end else begin
							n_q           <= current_q[NB-1:0];
							after_clear_q <= 1'b0;
							state_q       <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					spf_q       <= map_rdata;
					count_q     <= count_nx;
					current_q   <= current_q + 1'b1;
					res_num_q   <= lps_pkg::NUMBER_W'(n_q);
					res_prime_q <= map_rdata == '0;
					res_cnt_q   <= lps_pkg::PCOUNT_W'(count_nx);
					res_done_q  <= 1'b0;
					j_q         <= '0;
					state_q     <= (count_nx == '0) ? S_OUT : S_RD;
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					p_q     <= list_rdata;
					prod_s1 <= PW'(n_q) * PW'(list_rdata);
					sq_s1   <= PW'(list_rdata) * PW'(list_rdata);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (fin_cmp) begin
						state_q <= fin_state;
					end else if (need_div) begin
						rem_q     <= '0;
						div_cnt_q <= DCW'(NB - 1);
						state_q   <= S_DIV;
					end else begin
						j_q     <= j_nx;
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (!div_last) begin
						rem_q     <= rem_nx;
						div_cnt_q <= div_cnt_q - 1'b1;
					end else if (fin_div) begin
						state_q <= fin_state;
					end else begin
						j_q     <= j_nx;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					state_q <= fin_state;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = state_q != S_IDLE;
	assign out_valid   = out_valid_q;
	assign number      = number_q;
	assign is_prime    = is_prime_q;
	assign prime_count = prime_count_q;
	assign done_res    = done_res_q;

endmodule

// ===== sv/lps_checker.sv =====
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks on the sieve output channel.
// ----------------------------------------------------------------------------
`include "linear_prime_sieve_defines.svh"

module lps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [lps_pkg::NUMBER_W-1:0] number,
	input logic                         is_prime,
	input logic [lps_pkg::PCOUNT_W-1:0] prime_count,
	input logic                         done_res
);

	logic [lps_pkg::NUMBER_W+lps_pkg::PCOUNT_W+1:0] res_bits;

	assign res_bits = {number, is_prime, prime_count, done_res};

	`LPS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`LPS_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(res_bits))
	`LPS_ASSERT_IMP(a_done_empty, clk, arst_n, out_valid && done_res, (number == '0) && !is_prime)
	`LPS_ASSERT_IMP(a_prime_live, clk, arst_n, out_valid && is_prime, !done_res)

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (.*);

// ===== tb/linear_prime_sieve_tb.sv =====
// ----------------------------------------------------------------------------
// linear_prime_sieve_tb
// Self-checking bench for the linear prime sieve. A directed table of items
// and limit writes runs first, then sieve runs with random limits, restarts
// and run lengths. Both handshake sides idle at random. Every result is
// compared field by field against its table entry where the row gives one,
// else against an in-bench sieve tracking the map, prime list and count.
// ----------------------------------------------------------------------------
module linear_prime_sieve_tb;

	localparam int SIEVE_MAX     = 512;
	localparam int SIEVE_SLOTS   = 128;
	localparam int RANDOM_ITEMS  = 700;
	localparam int SETTLE_CYCLES = SIEVE_MAX + 256;
	localparam int NUM_ROWS      = 26;

	typedef struct packed {
		logic [lps_pkg::NUMBER_W-1:0] number;
		logic                         is_prime;
		logic [lps_pkg::PCOUNT_W-1:0] count;
		logic                         done;
	} sieve_res_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_RESTART, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [lps_pkg::LIMIT_W-1:0] arg;
		logic                        typed;
		sieve_res_t                  want;
	} plan_row_t;

	localparam plan_row_t PLAN [NUM_ROWS] = '{
		'{ROW_ITEM,    0,                    1, '{2, 1, 1, 0}},
		'{ROW_ITEM,    0,                    1, '{3, 1, 2, 0}},
		'{ROW_ITEM,    0,                    1, '{4, 0, 2, 0}},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_RESTART, 0,                    1, '{0, 0, 0, 0}},
		'{ROW_ITEM,    0,                    1, '{2, 1, 1, 0}},
		'{ROW_LIMIT,   3,                    0, '0},
		'{ROW_ITEM,    0,                    1, '{0, 0, 1, 1}},
		'{ROW_ITEM,    0,                    1, '{0, 0, 1, 1}},
		'{ROW_RESTART, 0,                    1, '{0, 0, 0, 0}},
		'{ROW_ITEM,    0,                    1, '{2, 1, 1, 0}},
		'{ROW_ITEM,    0,                    1, '{0, 0, 1, 1}},
		'{ROW_LIMIT,   lps_pkg::LIMIT_RESET, 0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_LIMIT,   10,                   0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_LIMIT,   SIEVE_MAX,            0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_ITEM,    0,                    0, '0},
		'{ROW_RESTART, 0,                    0, '0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         restart;
	logic                         out_valid;
	logic                         out_stall;
	logic [lps_pkg::NUMBER_W-1:0] number;
	logic                         is_prime;
	logic [lps_pkg::PCOUNT_W-1:0] prime_count;
	logic                         done_res;
	logic                         cfg_wr_en;
	logic [lps_pkg::LIMIT_W-1:0]  cfg_wr_data;

	// sieve state mirrored by the bench
	bit                           marked_q [SIEVE_MAX];
	int unsigned                  primes_q [SIEVE_SLOTS];
	int unsigned                  next_value_q;
	int unsigned                  found_q;
	logic [lps_pkg::LIMIT_W-1:0]  limit_q;

	sieve_res_t                   pending_q [$];
	int                           mismatches;
	bit                           no_idle;

	linear_prime_sieve #(
		.MAX_N      (SIEVE_MAX),
		.PRIME_SLOTS(SIEVE_SLOTS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.number     (number),
		.is_prime   (is_prime),
		.prime_count(prime_count),
		.done_res   (done_res),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void clear_sieve();
		foreach (marked_q[i])
			marked_q[i] = 1'b0;
		next_value_q = lps_pkg::START_VALUE;
		found_q      = 0;
	endfunction

	function automatic int unsigned effective_limit();
		return (limit_q < SIEVE_MAX) ? limit_q : SIEVE_MAX;
	endfunction

	function automatic sieve_res_t sieve_step(input bit rs);
		int unsigned       eff;
		int unsigned       n;
		int unsigned       p;
		longint unsigned   prod;
		bit                prime;
		int                j;
		sieve_res_t        r;
		r   = '0;
		eff = effective_limit();
		n   = next_value_q;
		if (rs) begin
			clear_sieve();
			return r;
		end
		if (n >= eff) begin
			r.count = found_q[lps_pkg::PCOUNT_W-1:0];
			r.done  = 1'b1;
			return r;
		end
		prime = !marked_q[n];
		if (prime && found_q < SIEVE_SLOTS) begin
			primes_q[found_q] = n;
			found_q++;
		end
		for (j = 0; j < int'(found_q); j++) begin
			p    = primes_q[j];
			prod = longint'(n) * p;
			if (p == 0 || prod >= eff)
				break;
			marked_q[int'(prod)] = 1'b1;
			if (n % p == 0)
				break;
		end
		next_value_q = n + 1;
		r.number     = n[lps_pkg::NUMBER_W-1:0];
		r.is_prime   = prime;
		r.count      = found_q[lps_pkg::PCOUNT_W-1:0];
		return r;
	endfunction

	// mostly none or short, some long, none while no_idle is set
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input bit rs, input bit typed, input sieve_res_t typed_res);
		int         gap;
		sieve_res_t pred;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		do @(posedge clk); while (in_stall !== 1'b0);
		pred = sieve_step(rs);
		pending_q.insert(pending_q.size(), typed ? typed_res : pred);
	endtask

	// sender holds off until all results are in and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input int unsigned value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value[lps_pkg::LIMIT_W-1:0];
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		limit_q = value[lps_pkg::LIMIT_W-1:0];
	endtask

	function automatic int unsigned pick_limit();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 3;
		if (r == 1)
			return lps_pkg::LIMIT_RESET;
		if (r == 2)
			return $urandom_range(SIEVE_MAX, lps_pkg::LIMIT_RESET);
		if (r == 3)
			return SIEVE_MAX;
		if (r < 12)
			return $urandom_range(3, 64);
		return $urandom_range(3, SIEVE_MAX);
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		sieve_res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected item, expected none got number %0d",
					$time, number);
				mismatches++;
			end else begin
				want = pending_q.pop_front();
				check_field("number", want.number, number);
				check_field("is_prime", want.is_prime, is_prime);
				check_field("prime_count", want.count, prime_count);
				check_field("done_res", want.done, done_res);
			end
		end
	end

	initial begin : sink_pace
		int hold;
		forever begin
			hold = idle_len();
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int  sent;
		int  len;
		int  cap;
		int  to_done;
		bit  rs;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		restart     = 1'b0;
		out_stall   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		mismatches  = 0;
		no_idle     = 1'b0;
		limit_q     = lps_pkg::LIMIT_RESET;
		clear_sieve();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_ROWS; i++) begin
			case (PLAN[i].kind)
				ROW_LIMIT: begin
					settle();
					write_limit(PLAN[i].arg);
				end
				ROW_RESTART: send_item(1'b1, PLAN[i].typed, PLAN[i].want);
				default: send_item(1'b0, PLAN[i].typed, PLAN[i].want);
			endcase
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			no_idle = ($urandom_range(0, 3) == 0);
			write_limit(pick_limit());
			if ($urandom_range(0, 2) != 0) begin
				send_item(1'b1, 1'b0, '0);
				sent++;
			end
			to_done = int'(effective_limit()) - int'(next_value_q);
			len     = (to_done > 0 ? to_done : 0) + $urandom_range(1, 3);
			cap     = $urandom_range(20, 90);
			if (len > cap)
				len = cap;
			for (int k = 0; k < len; k++) begin
				rs = ($urandom_range(0, 49) == 0);
				send_item(rs, 1'b0, '0);
			end
			sent += len;
		end

		no_idle = 1'b0;
		settle();
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== linear_prime_sieve.f =====
+incdir+sv
sv/lps_pkg.sv
sv/lps_ram.sv
sv/linear_prime_sieve.sv
sv/lps_checker.sv
tb/linear_prime_sieve_tb.sv
